// ----- rtl/core/epoch_seconds_to_calendar_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the epoch seconds to calendar converter
// Shorthand for clocked checks, disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// Same-cycle implication check
`define ECAL_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication check starting in the cycle after the antecedent
`define ECAL_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/ecal_pkg.sv -----
// ---------------------------------------------------------------------------
// ecal_pkg
// Constants and month tables for the epoch seconds to calendar converter.
// ---------------------------------------------------------------------------
package ecal_pkg;

  // Range limits in seconds since 1970
  localparam logic [31:0] BASE_OFFSET = 32'd63072000;   // 1972-01-01
  localparam logic [31:0] END_OFFSET  = 32'd4102444800; // 2100-01-01

  localparam logic [11:0] BASE_YEAR    = 12'd1972;
  localparam logic [6:0]  FAT_YEAR_ADJ = 7'd8;           // 1980 - 1972

  // Reciprocals, rounded down; each quotient is fixed up by one compare
  localparam logic [25:0] RECIP_675  = 26'd50903316;    // 2^35 / 675
  localparam int          SHIFT_675  = 35;
  localparam logic [15:0] RECIP_1461 = 16'd45933;       // 2^26 / 1461
  localparam int          SHIFT_1461 = 26;
  localparam logic [16:0] RECIP_60_T = 17'd69905;       // 2^22 / 60
  localparam int          SHIFT_60_T = 22;
  localparam logic [10:0] RECIP_60_M = 11'd1092;        // 2^16 / 60
  localparam int          SHIFT_60_M = 16;

  localparam logic [9:0]  DAY_SECS_HI = 10'd675;        // 86400 / 128
  localparam logic [10:0] CYCLE_DAYS  = 11'd1461;

  // Days before the first of each month, month index 0..11
  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
    logic [8:0] base;
    begin
      case (idx)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd0;
      endcase
      if (leap && idx >= 4'd2) begin
        base = base + 9'd1;
      end
      return base;
    end
  endfunction

endpackage

// ----- rtl/core/epoch_seconds_to_calendar.sv -----
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Pipelined conversion of a seconds count to calendar and FAT date/time.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: drive epoch_seconds and raise start; the item is taken at
//   any rising edge where start is high and busy is low. busy is only high
//   during reset, so one item may enter every cycle.
//   Result channel: done is high for exactly one cycle with all result
//   ports valid; the receiver must take it then, it cannot stall.
//   done rises together with the output register, once the item has passed
//   through stage registers s1 to s6.
//   Throughput: one item per cycle, set by a seven-stage pipeline
//   (range check, day divide, day fix-up, cycle and minute divide,
//   their fix-ups, year/hour split, month search and output register).
//   Items outside 1972..2099 give out_of_range high and all other fields 0.
//   Reset (synchronous) empties the pipeline; items in flight are dropped.
// ---------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_assert.svh"

module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] epoch_seconds,
  output logic        done,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [15:0] fat_date,
  output logic [15:0] fat_time,
  output logic        out_of_range
);

  // Valid bits, one per stage
  logic [6:0] vld;

  // Stage 1 registers
  logic [31:0] s1_rel;
  logic        s1_oor;
  // Stage 2 registers
  logic [24:0] s2_hi;
  logic [6:0]  s2_lo;
  logic [15:0] s2_q;
  logic        s2_oor;
  // Stage 3 registers
  logic [15:0] s3_day;
  logic [16:0] s3_tod;
  logic        s3_oor;
  // Stage 4 registers
  logic [15:0] s4_day;
  logic [16:0] s4_tod;
  logic [5:0]  s4_cyc;
  logic [11:0] s4_mins;
  logic        s4_oor;
  // Stage 5 registers
  logic [10:0] s5_dc;
  logic [5:0]  s5_cyc;
  logic [10:0] s5_mins;
  logic [5:0]  s5_ss;
  logic        s5_oor;
  // Stage 6 registers
  logic [8:0]  s6_doy;
  logic        s6_leap;
  logic [6:0]  s6_yi;
  logic [5:0]  s6_hh;
  logic [10:0] s6_mins;
  logic [5:0]  s6_ss;
  logic        s6_oor;

  // Next values
  logic [31:0] rel_next;
  logic        oor_next;
  logic [50:0] prod_675;
  logic [24:0] rem_675_full;
  logic [10:0] rem_675;
  logic [15:0] day_next;
  logic [9:0]  rem_day_next;
  logic [31:0] prod_1461;
  logic [33:0] prod_60_t;
  logic [15:0] dc_full;
  logic [10:0] dc_raw;
  logic [10:0] dc_next;
  logic [5:0]  cyc_next;
  logic [16:0] ss_full;
  logic [6:0]  ss_raw;
  logic [5:0]  ss_next;
  logic [10:0] mins_next;
  logic [1:0]  yq_next;
  logic [8:0]  doy_next;
  logic [21:0] prod_60_m;
  logic [10:0] mm_full;
  logic [6:0]  mm_raw;
  logic [5:0]  mm_next;
  logic [4:0]  hh_next;
  logic [3:0]  mcount;
  logic [3:0]  month_next;
  logic [8:0]  dom_full;
  logic [4:0]  dom_next;
  logic [6:0]  fat_year;

  assign busy = rst;

  // Stage 1: offset from 1972 and range check
  always_comb begin
    rel_next = epoch_seconds - ecal_pkg::BASE_OFFSET;
    oor_next = (epoch_seconds < ecal_pkg::BASE_OFFSET) ||
               (epoch_seconds >= ecal_pkg::END_OFFSET);
  end

  // Stage 2: day count estimate, rel / 86400 = (rel >> 7) / 675
  assign prod_675 = s1_rel[31:7] * ecal_pkg::RECIP_675;

  // Stage 3: fix up day count, remainder forms time of day
  always_comb begin
    rem_675_full = s2_hi - 25'(s2_q * ecal_pkg::DAY_SECS_HI);
    rem_675      = rem_675_full[10:0];
    if (rem_675 >= {1'b0, ecal_pkg::DAY_SECS_HI}) begin
      day_next     = s2_q + 16'd1;
      rem_day_next = 10'(rem_675 - {1'b0, ecal_pkg::DAY_SECS_HI});
    end else begin
      day_next     = s2_q;
      rem_day_next = rem_675[9:0];
    end
  end

  // Stage 4: 4-year cycle estimate and minute estimate
  assign prod_1461 = s3_day * ecal_pkg::RECIP_1461;
  assign prod_60_t = s3_tod * ecal_pkg::RECIP_60_T;

  // Stage 5: fix up cycle and minute counts
  always_comb begin
    dc_full = s4_day - 16'(s4_cyc * ecal_pkg::CYCLE_DAYS);
    dc_raw  = dc_full[10:0];
    if (dc_raw >= ecal_pkg::CYCLE_DAYS) begin
      dc_next  = dc_raw - ecal_pkg::CYCLE_DAYS;
      cyc_next = s4_cyc + 6'd1;
    end else begin
      dc_next  = dc_raw;
      cyc_next = s4_cyc;
    end
    ss_full = s4_tod - 17'(s4_mins * 6'd60);
    ss_raw  = ss_full[6:0];
    if (ss_raw >= 7'd60) begin
      ss_next   = 6'(ss_raw - 7'd60);
      mins_next = s4_mins[10:0] + 11'd1;
    end else begin
      ss_next   = ss_raw[5:0];
      mins_next = s4_mins[10:0];
    end
  end

  // Stage 6: year within cycle, day of year, hour estimate
  always_comb begin
    if (s5_dc <= 11'd365) begin
      yq_next  = 2'd0;
      doy_next = 9'(s5_dc + 11'd1);
    end else if (s5_dc <= 11'd730) begin
      yq_next  = 2'd1;
      doy_next = 9'(s5_dc - 11'd365);
    end else if (s5_dc <= 11'd1095) begin
      yq_next  = 2'd2;
      doy_next = 9'(s5_dc - 11'd730);
    end else begin
      yq_next  = 2'd3;
      doy_next = 9'(s5_dc - 11'd1095);
    end
  end

  assign prod_60_m = s5_mins * ecal_pkg::RECIP_60_M;

  // Stage 7: month search, day of month, hour fix-up
  always_comb begin
    mcount = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (s6_doy > ecal_pkg::cum_days(s6_leap, 4'(i))) begin
        mcount = mcount + 4'd1;
      end
    end
    month_next = mcount + 4'd1;
    dom_full   = s6_doy - ecal_pkg::cum_days(s6_leap, mcount);
    dom_next   = dom_full[4:0];
    mm_full    = s6_mins - 11'(s6_hh * 6'd60);
    mm_raw     = mm_full[6:0];
    if (mm_raw >= 7'd60) begin
      mm_next = 6'(mm_raw - 7'd60);
      hh_next = 5'(s6_hh + 6'd1);
    end else begin
      mm_next = mm_raw[5:0];
      hh_next = s6_hh[4:0];
    end
    fat_year = s6_yi - ecal_pkg::FAT_YEAR_ADJ;
  end

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:0], start & ~busy};
    end
  end

  // Data pipeline
  always_ff @(posedge clk) begin
    s1_rel  <= rel_next;
    s1_oor  <= oor_next;

    s2_hi   <= s1_rel[31:7];
    s2_lo   <= s1_rel[6:0];
    s2_q    <= prod_675[50:ecal_pkg::SHIFT_675];
    s2_oor  <= s1_oor;

    s3_day  <= day_next;
    s3_tod  <= {rem_day_next, s2_lo};
    s3_oor  <= s2_oor;

    s4_day  <= s3_day;
    s4_tod  <= s3_tod;
    s4_cyc  <= prod_1461[31:ecal_pkg::SHIFT_1461];
    s4_mins <= prod_60_t[33:ecal_pkg::SHIFT_60_T];
    s4_oor  <= s3_oor;

    s5_dc   <= dc_next;
    s5_cyc  <= cyc_next;
    s5_mins <= mins_next;
    s5_ss   <= ss_next;
    s5_oor  <= s4_oor;

    s6_doy  <= doy_next;
    s6_leap <= (yq_next == 2'd0);
    s6_yi   <= {s5_cyc[4:0], yq_next};
    s6_hh   <= prod_60_m[21:ecal_pkg::SHIFT_60_M];
    s6_mins <= s5_mins;
    s6_ss   <= s5_ss;
    s6_oor  <= s5_oor;

    // Output register, fields forced to zero when out of range
    out_of_range <= s6_oor;
    if (s6_oor) begin
      year         <= '0;
      month        <= '0;
      day_of_month <= '0;
      hour         <= '0;
      minute       <= '0;
      second       <= '0;
      fat_date     <= '0;
      fat_time     <= '0;
    end else begin
      year         <= ecal_pkg::BASE_YEAR + 12'(s6_yi);
      month        <= month_next;
      day_of_month <= dom_next;
      hour         <= hh_next;
      minute       <= mm_next;
      second       <= s6_ss;
      fat_date     <= {fat_year, month_next, dom_next};
      fat_time     <= {hh_next, mm_next, s6_ss[5:1]};
    end
  end

  assign done = vld[6];

  // Checks
  `ECAL_CHECK_NEXT(a_latency, start && !busy, ##6 done, "item did not emerge after pipeline latency")
  `ECAL_CHECK(a_date_ok, done && !out_of_range, month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1, "bad month or day")
  `ECAL_CHECK(a_time_ok, done, hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59, "time of day out of range")
  `ECAL_CHECK(a_oor_zero, done && out_of_range, year == 12'd0 && fat_date == 16'd0 && fat_time == 16'd0, "fields not cleared when out of range")

endmodule
